// ===== rtl/mbps_pkg.sv =====
package mbps_pkg;

    // longest pattern the window holds
    localparam int MAX_PATTERN = 16;
    // pattern bytes that the registers carry
    localparam int REG_BYTES   = 16;
    localparam int LEN_W       = 5;
    localparam int WIN_IDX_W   = $clog2(MAX_PATTERN);
    localparam int POS_W       = 32;
    localparam int REG_W       = 64;
    localparam int ADDR_W      = 6;
    localparam int PAT_W       = 8 * REG_BYTES;

    typedef enum logic [2:0] {
        REG_PATTERN_LENGTH = 3'd0,
        REG_PATTERN_LOW    = 3'd1,
        REG_PATTERN_HIGH   = 3'd2,
        REG_MASK_LOW       = 3'd3,
        REG_MASK_HIGH      = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [LEN_W-1:0] pattern_length;
        logic [PAT_W-1:0] pattern;
        logic [PAT_W-1:0] mask;
    } t_cfg;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] match_position;
    } t_result;

    // zero acts as one, anything past the window acts as the window size
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] l;
        l = len;
        if (l == '0) begin
            l = LEN_W'(1);
        end
        if (l > LEN_W'(REG_BYTES)) begin
            l = LEN_W'(REG_BYTES);
        end
        if (l > LEN_W'(MAX_PATTERN)) begin
            l = LEN_W'(MAX_PATTERN);
        end
        return l;
    endfunction

endpackage

// ===== rtl/mbps_if.sv =====
interface mbps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_search;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output start_of_search,
                    output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input start_of_search,
                    input end_of_stream, output ready);
endinterface

interface mbps_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] match_position;

    modport source (output valid, output found, output match_position, input ready);
    modport sink   (input valid, input found, input match_position, output ready);
endinterface

// ===== rtl/mbps_cfg_regs.sv =====
module mbps_cfg_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [mbps_pkg::ADDR_W-1:0] paddr,
    input  logic [mbps_pkg::REG_W-1:0]  pwdata,
    output logic [mbps_pkg::REG_W-1:0]  prdata,
    output logic                      pready,
    output mbps_pkg::t_cfg            o_cfg
);
    import mbps_pkg::*;

    logic [LEN_W-1:0] r_len;
    logic [REG_W-1:0] r_pat_lo;
    logic [REG_W-1:0] r_pat_hi;
    logic [REG_W-1:0] r_mask_lo;
    logic [REG_W-1:0] r_mask_hi;
    logic             wr_en;
    t_reg_idx         idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = t_reg_idx'(paddr[ADDR_W-1:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= LEN_W'(1);
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_mask_lo <= '1;
            r_mask_hi <= '1;
        end else if (wr_en) begin
            unique case (idx)
                REG_PATTERN_LENGTH: r_len     <= pwdata[LEN_W-1:0];
                REG_PATTERN_LOW:    r_pat_lo  <= pwdata;
                REG_PATTERN_HIGH:   r_pat_hi  <= pwdata;
                REG_MASK_LOW:       r_mask_lo <= pwdata;
                REG_MASK_HIGH:      r_mask_hi <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_PATTERN_LENGTH: prdata = REG_W'(r_len);
            REG_PATTERN_LOW:    prdata = r_pat_lo;
            REG_PATTERN_HIGH:   prdata = r_pat_hi;
            REG_MASK_LOW:       prdata = r_mask_lo;
            REG_MASK_HIGH:      prdata = r_mask_hi;
            default:            prdata = '0;
        endcase
    end

    assign o_cfg.pattern_length = r_len;
    assign o_cfg.pattern        = {r_pat_hi, r_pat_lo};
    assign o_cfg.mask           = {r_mask_hi, r_mask_lo};

endmodule

// ===== rtl/mbps_match_core.sv =====
module mbps_match_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_data_byte,
    input  logic             i_start,
    input  logic             i_last,
    input  mbps_pkg::t_cfg   i_cfg,
    output logic             o_emit,
    output mbps_pkg::t_result o_result
);
    import mbps_pkg::*;

    logic [7:0]       r_win [MAX_PATTERN];
    logic [POS_W-1:0] r_seen;
    logic             r_done;

    logic [7:0]       n_win [MAX_PATTERN];
    logic [POS_W-1:0] n_seen;
    logic             n_done;

    logic [POS_W-1:0] seen_base;
    logic             done_base;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] tap;
    logic             match;
    logic             cmp_ok;

    assign len       = eff_len(i_cfg.pattern_length);
    assign seen_base = i_start ? '0 : r_seen;
    assign done_base = i_start ? 1'b0 : r_done;

    // window after this beat shifts in, entry 0 newest
    always_comb begin
        for (int j = 0; j < MAX_PATTERN; j++) begin
            if (j == 0) begin
                n_win[j] = i_data_byte;
            end else begin
                n_win[j] = i_start ? 8'h00 : r_win[j-1];
            end
        end
    end

    assign n_seen = (seen_base == '1) ? seen_base : seen_base + POS_W'(1);

    // pattern byte i lines up with window entry len-1-i
    always_comb begin
        cmp_ok = 1'b1;
        tap    = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            tap = len - LEN_W'(1) - LEN_W'(i);
            if (LEN_W'(i) < len) begin
                if ((n_win[tap[WIN_IDX_W-1:0]] & i_cfg.mask[8*i +: 8]) !=
                    (i_cfg.pattern[8*i +: 8] & i_cfg.mask[8*i +: 8])) begin
                    cmp_ok = 1'b0;
                end
            end
        end
    end

    assign match = !done_base && cmp_ok &&
                   ((seen_base >= POS_W'(len) - POS_W'(1)) || (n_seen == '1));
    assign o_emit = !done_base && (match || i_last);
    assign n_done = done_base || o_emit;

    assign o_result.found          = match;
    assign o_result.match_position = match ?
                                     seen_base - POS_W'(len) + POS_W'(1) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_done <= 1'b0;
            for (int j = 0; j < MAX_PATTERN; j++) begin
                r_win[j] <= 8'h00;
            end
        end else if (i_accept) begin
            r_done <= n_done;
            if (!done_base) begin
                r_seen <= n_seen;
                for (int j = 0; j < MAX_PATTERN; j++) begin
                    r_win[j] <= n_win[j];
                end
            end
        end
    end

endmodule

// ===== rtl/mbps_out_reg.sv =====
module mbps_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  mbps_pkg::t_result i_result,
    output logic              o_free,
    mbps_out_if.source        o_res
);
    import mbps_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_res.valid          = r_valid;
    assign o_res.found          = r_result.found;
    assign o_res.match_position = r_result.match_position;

endmodule

// ===== rtl/masked_byte_pattern_search_top.sv =====
// Masked byte pattern search: takes one stream byte per cycle and reports, once per
// search, the start position of the first place where the first pattern_length
// pattern bytes match under their masks, or found = 0 when the stream ends first.
// A beat with start_of_search begins a fresh search; after a report, beats are
// taken and dropped until the next start. The whole window compare sits between the
// window registers and the result register, so a new byte is accepted every cycle
// while the result register is free or being read. Registers sit at byte addresses
// 8*i; write them only while the block is idle.
module masked_byte_pattern_search_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbps_pkg::ADDR_W-1:0] paddr,
    input  logic [mbps_pkg::REG_W-1:0]  pwdata,
    output logic [mbps_pkg::REG_W-1:0]  prdata,
    output logic                        pready,
    mbps_in_if.sink                     i_byte,
    mbps_out_if.source                  o_result
);
    import mbps_pkg::*;

    t_cfg    cfg;
    t_result core_res;
    logic    core_emit;
    logic    out_free;
    logic    accept;

    assign i_byte.ready = out_free;
    assign accept       = i_byte.valid && out_free;

    mbps_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mbps_match_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_byte.data_byte),
        .i_start     (i_byte.start_of_search),
        .i_last      (i_byte.end_of_stream),
        .i_cfg       (cfg),
        .o_emit      (core_emit),
        .o_result    (core_res)
    );

    mbps_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept && core_emit),
        .i_result (core_res),
        .o_free   (out_free),
        .o_res    (o_result)
    );

endmodule
